>>> design/x86_64_page_table_walker_assert.svh
// Assertion macros for the page table walker checks
`ifndef X86_64_PAGE_TABLE_WALKER_ASSERT_SVH
`define X86_64_PAGE_TABLE_WALKER_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define PTW_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("page table walker check failed");

// next-cycle implication, clocked on i_clk, off during reset
`define PTW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("page table walker check failed");

`endif

>>> design/ptw_pkg.sv
`default_nettype none

package ptw_pkg;

    localparam int PHYS_ADDR_BITS = 52;

    localparam int W_ADDR   = 52;
    localparam int W_VA     = 57;
    localparam int W_ENTRY  = 64;
    localparam int W_STATUS = 2;
    localparam int W_LEVEL  = 3;
    localparam int W_SIZE   = 2;
    localparam int W_IDX    = 9;
    localparam int PAGE_BITS = 12;

    // slave tdata: root_table, virtual_address, entry_value, read_ok
    localparam int S_ROOT_LSB  = 0;
    localparam int S_VA_LSB    = S_ROOT_LSB + W_ADDR;
    localparam int S_ENTRY_LSB = S_VA_LSB + W_VA;
    localparam int S_OK_BIT    = S_ENTRY_LSB + W_ENTRY;
    localparam int W_S_DATA    = ((S_OK_BIT + 1 + 7) / 8) * 8;

    // master tdata: request_address, physical_address, status, fail_level, page_size
    localparam int M_REQ_LSB    = 0;
    localparam int M_PA_LSB     = M_REQ_LSB + W_ADDR;
    localparam int M_STATUS_LSB = M_PA_LSB + W_ADDR;
    localparam int M_FAIL_LSB   = M_STATUS_LSB + W_STATUS;
    localparam int M_SIZE_LSB   = M_FAIL_LSB + W_LEVEL;
    localparam int M_USED       = M_SIZE_LSB + W_SIZE;
    localparam int W_M_DATA     = ((M_USED + 7) / 8) * 8;

    localparam int W_PADDR = 3;
    localparam int W_PDATA = 32;
    localparam logic REG_FIVE_LEVEL = 1'b0;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    localparam logic RES_REQUEST = 1'b0;
    localparam logic RES_FINISH  = 1'b1;

    localparam logic [W_STATUS-1:0] ST_OK          = 2'd0;
    localparam logic [W_STATUS-1:0] ST_READ_FAIL   = 2'd1;
    localparam logic [W_STATUS-1:0] ST_NOT_PRESENT = 2'd2;

    localparam logic [W_LEVEL-1:0] LVL_PML5 = 3'd0;
    localparam logic [W_LEVEL-1:0] LVL_PML4 = 3'd1;
    localparam logic [W_LEVEL-1:0] LVL_PDPT = 3'd2;
    localparam logic [W_LEVEL-1:0] LVL_PD   = 3'd3;
    localparam logic [W_LEVEL-1:0] LVL_PT   = 3'd4;

    localparam logic [W_SIZE-1:0] SZ_4K = 2'd0;
    localparam logic [W_SIZE-1:0] SZ_2M = 2'd1;
    localparam logic [W_SIZE-1:0] SZ_1G = 2'd2;

    localparam int BIT_PRESENT = 0;
    localparam int BIT_PS      = 7;

endpackage

`default_nettype wire

>>> design/x86_64_page_table_walker.sv
`default_nettype none

// Page table walker for four-level and five-level x86-64 paging. A start item
// (tuser = 0) carries the root table address and the virtual address; the
// block answers with a request for the first 8-byte table entry (PML5 when
// five_level_mode is set, else PML4). Each reply item (tuser = 1) carries the
// entry read and its read_ok flag; the block answers with the next level's
// request or with a finish item holding the physical address and page size,
// or the failing level and cause. A start during a walk restarts it; a reply
// with no walk running is dropped without a result. One item is taken every
// cycle unless the input stalls: each item passes an input register and then a
// result register, which offers its result. The input stalls only while both
// registers hold an item and the result is not taken. The reply to a request
// may be offered in the cycle after that request is taken. five_level_mode is
// sampled when a start item is processed.
module x86_64_page_table_walker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // root_table[51:0], virtual_address[108:52], entry_value[172:109], read_ok[173]
    input  wire logic [ptw_pkg::W_S_DATA-1:0]  i_s_axis_tdata,
    // kind
    input  wire logic                          i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // request_address[51:0], physical_address[103:52], status[105:104],
    // fail_level[108:106], leaf_size[110:109]
    output logic [ptw_pkg::W_M_DATA-1:0]       o_m_axis_tdata,
    // result_kind
    output logic                               o_m_axis_tuser,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ptw_pkg::W_PADDR-1:0]   paddr,
    input  wire logic [ptw_pkg::W_PDATA-1:0]   pwdata,
    output logic [ptw_pkg::W_PDATA-1:0]        prdata,
    output logic                               pready
);
    import ptw_pkg::*;

    localparam int W_FRAME = PHYS_ADDR_BITS - PAGE_BITS;

    function automatic logic [W_IDX-1:0] va_index(input logic [W_VA-1:0] va,
                                                 input logic [W_LEVEL-1:0] lvl);
        logic [W_IDX-1:0] idx;
        unique case (lvl)
            LVL_PML5: idx = va[56:48];
            LVL_PML4: idx = va[47:39];
            LVL_PDPT: idx = va[38:30];
            LVL_PD:   idx = va[29:21];
            default:  idx = va[20:12];
        endcase
        return idx;
    endfunction

    logic               r_mode;
    logic               r_busy;
    logic [W_LEVEL-1:0] r_level;
    logic [W_VA-1:0]    r_hva;

    logic               r_in_valid;
    logic               r_in_kind;
    logic [W_FRAME-1:0] r_in_root;
    logic [W_VA-1:0]    r_in_va;
    logic [W_FRAME-1:0] r_in_frame;
    logic               r_in_present;
    logic               r_in_ps;
    logic               r_in_ok;

    logic                r_out_valid;
    logic                r_out_kind;
    logic [W_ADDR-1:0]   r_out_req;
    logic [W_ADDR-1:0]   r_out_pa;
    logic [W_STATUS-1:0] r_out_status;
    logic [W_LEVEL-1:0]  r_out_fail;
    logic [W_SIZE-1:0]   r_out_size;

    logic                      n_busy;
    logic [W_LEVEL-1:0]        n_level;
    logic [W_VA-1:0]           n_hva;
    logic                      n_produce;
    logic                      n_kind;
    logic [PHYS_ADDR_BITS-1:0] n_req;
    logic [PHYS_ADDR_BITS-1:0] n_pa;
    logic [W_STATUS-1:0]       n_status;
    logic [W_LEVEL-1:0]        n_fail;
    logic [W_SIZE-1:0]         n_size;

    logic                      advance;
    logic                      s_take;
    logic                      cfg_write;
    logic [W_LEVEL-1:0]        start_level;
    logic [W_LEVEL-1:0]        next_level;
    logic [PHYS_ADDR_BITS-1:0] page_offset;
    logic [PHYS_ADDR_BITS-1:0] pa_sum;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign s_take          = i_s_axis_tvalid && o_s_axis_tready;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[W_PADDR-1:2] == REG_FIVE_LEVEL);

    always_comb begin
        prdata = '0;
        if (paddr[W_PADDR-1:2] == REG_FIVE_LEVEL) begin
            prdata[0] = r_mode;
        end
    end

    assign start_level = r_mode ? LVL_PML5 : LVL_PML4;
    assign next_level  = r_level + W_LEVEL'(1);

    always_comb begin
        unique case (r_level)
            LVL_PDPT: page_offset = PHYS_ADDR_BITS'(r_hva[29:0]);
            LVL_PD:   page_offset = PHYS_ADDR_BITS'(r_hva[20:0]);
            default:  page_offset = PHYS_ADDR_BITS'(r_hva[11:0]);
        endcase
    end

    assign pa_sum = {r_in_frame, {PAGE_BITS{1'b0}}} + page_offset;

    always_comb begin
        n_busy    = r_busy;
        n_level   = r_level;
        n_hva     = r_hva;
        n_produce = 1'b0;
        n_kind    = RES_REQUEST;
        n_req     = '0;
        n_pa      = '0;
        n_status  = ST_OK;
        n_fail    = LVL_PML5;
        n_size    = SZ_4K;
        if (r_in_kind == KIND_START) begin
            n_hva     = r_in_va;
            n_level   = start_level;
            n_busy    = 1'b1;
            n_produce = 1'b1;
            n_req     = {r_in_root, va_index(r_in_va, start_level), 3'b000};
        end else if (r_busy) begin
            n_produce = 1'b1;
            n_kind    = RES_FINISH;
            n_busy    = 1'b0;
            priority if (!r_in_ok) begin
                n_status = ST_READ_FAIL;
                n_fail   = r_level;
            end else if (!r_in_present) begin
                n_status = ST_NOT_PRESENT;
                n_fail   = r_level;
            end else if (r_level == LVL_PDPT && r_in_ps) begin
                n_pa   = pa_sum;
                n_size = SZ_1G;
            end else if (r_level == LVL_PD && r_in_ps) begin
                n_pa   = pa_sum;
                n_size = SZ_2M;
            end else if (r_level >= LVL_PT) begin
                n_pa   = pa_sum;
                n_size = SZ_4K;
            end else begin
                n_kind  = RES_REQUEST;
                n_busy  = 1'b1;
                n_level = next_level;
                n_req   = {r_in_frame, va_index(r_hva, next_level), 3'b000};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_busy      <= 1'b0;
            r_level     <= LVL_PML5;
            r_hva       <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_write) begin
                r_mode <= pwdata[0];
            end
            if (s_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_busy      <= n_busy;
                r_level     <= n_level;
                r_hva       <= n_hva;
                r_out_valid <= n_produce;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_in_kind    <= i_s_axis_tuser;
            r_in_root    <= i_s_axis_tdata[S_ROOT_LSB + PAGE_BITS +: W_FRAME];
            r_in_va      <= i_s_axis_tdata[S_VA_LSB +: W_VA];
            r_in_frame   <= i_s_axis_tdata[S_ENTRY_LSB + PAGE_BITS +: W_FRAME];
            r_in_present <= i_s_axis_tdata[S_ENTRY_LSB + BIT_PRESENT];
            r_in_ps      <= i_s_axis_tdata[S_ENTRY_LSB + BIT_PS];
            r_in_ok      <= i_s_axis_tdata[S_OK_BIT];
        end
        if (advance && n_produce) begin
            r_out_kind   <= n_kind;
            r_out_req    <= W_ADDR'(n_req);
            r_out_pa     <= W_ADDR'(n_pa);
            r_out_status <= n_status;
            r_out_fail   <= n_fail;
            r_out_size   <= n_size;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_kind;

    always_comb begin
        o_m_axis_tdata = '0;
        o_m_axis_tdata[M_REQ_LSB +: W_ADDR]      = r_out_req;
        o_m_axis_tdata[M_PA_LSB +: W_ADDR]       = r_out_pa;
        o_m_axis_tdata[M_STATUS_LSB +: W_STATUS] = r_out_status;
        o_m_axis_tdata[M_FAIL_LSB +: W_LEVEL]    = r_out_fail;
        o_m_axis_tdata[M_SIZE_LSB +: W_SIZE]     = r_out_size;
    end

endmodule

`default_nettype wire

>>> design/ptw_chk.sv
`default_nettype none

`include "x86_64_page_table_walker_assert.svh"

module ptw_chk (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_s_axis_tvalid,
    input wire logic                         o_s_axis_tready,
    input wire logic                         o_m_axis_tvalid,
    input wire logic                         i_m_axis_tready,
    input wire logic [ptw_pkg::W_M_DATA-1:0] o_m_axis_tdata,
    input wire logic                         o_m_axis_tuser
);
    import ptw_pkg::*;

    logic [W_ADDR-1:0]   req;
    logic [W_ADDR-1:0]   pa;
    logic [W_STATUS-1:0] status;
    logic [W_LEVEL-1:0]  fail;
    logic [W_SIZE-1:0]   size;

    assign req    = o_m_axis_tdata[M_REQ_LSB +: W_ADDR];
    assign pa     = o_m_axis_tdata[M_PA_LSB +: W_ADDR];
    assign status = o_m_axis_tdata[M_STATUS_LSB +: W_STATUS];
    assign fail   = o_m_axis_tdata[M_FAIL_LSB +: W_LEVEL];
    assign size   = o_m_axis_tdata[M_SIZE_LSB +: W_SIZE];

    `PTW_ASSERT_IMPLY(a_req_clean, o_m_axis_tvalid && o_m_axis_tuser == RES_REQUEST,
        pa == '0 && status == ST_OK && fail == LVL_PML5 && size == SZ_4K && req[2:0] == 3'b000)
    `PTW_ASSERT_IMPLY(a_fail_clean,
        o_m_axis_tvalid && o_m_axis_tuser == RES_FINISH && status != ST_OK,
        pa == '0 && req == '0 && size == SZ_4K
        && (status == ST_READ_FAIL || status == ST_NOT_PRESENT))
    `PTW_ASSERT_IMPLY(a_ok_clean,
        o_m_axis_tvalid && o_m_axis_tuser == RES_FINISH && status == ST_OK,
        req == '0 && fail == LVL_PML5 && (size == SZ_4K || size == SZ_2M || size == SZ_1G))
    `PTW_ASSERT_IMPLY(a_result_follows_item, $rose(o_m_axis_tvalid),
        $past(i_s_axis_tvalid && o_s_axis_tready, 2))
    `PTW_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))

endmodule

bind x86_64_page_table_walker ptw_chk u_ptw_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire

>>> tb/sv/x86_64_page_table_walker_tb.sv
`timescale 1ns / 1ps

module x86_64_page_table_walker_tb;
    import ptw_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 240;
    localparam int DRAIN_CYCLES = 6;
    localparam logic [63:0] E_PRESENT = 64'd1 << BIT_PRESENT;
    localparam logic [63:0] E_PS = 64'd1 << BIT_PS;

    typedef struct {
        logic               kind;
        logic [W_ADDR-1:0]  root;
        logic [W_VA-1:0]    va;
        logic [W_ENTRY-1:0] entry;
        logic               ok;
    } t_walk_item;

    typedef struct {
        logic                kind;
        logic [W_ADDR-1:0]   req;
        logic [W_ADDR-1:0]   pa;
        logic [W_STATUS-1:0] status;
        logic [W_LEVEL-1:0]  level;
        logic [W_SIZE-1:0]   page_sz;
    } t_walk_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [W_S_DATA-1:0]   i_s_axis_tdata = '0;
    logic                  i_s_axis_tuser = 1'b0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [W_M_DATA-1:0]   o_m_axis_tdata;
    logic                  o_m_axis_tuser;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [W_PADDR-1:0]    paddr = '0;
    logic [W_PDATA-1:0]    pwdata = '0;
    logic [W_PDATA-1:0]    prdata;
    logic                  pready;

    t_walk_item   walk_items[$];
    t_walk_result expected_walk_results[$];
    t_walk_item   cur_item;

    logic               mdl_five = 1'b0;
    logic [W_LEVEL-1:0] mdl_level = '0;
    logic               mdl_busy = 1'b0;
    logic [W_VA-1:0]    mdl_va = '0;

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  mismatch_cnt = 0;
    int  stim_count = 0;
    int  stall_cycles = 0;
    logic hold_start = 1'b0;

    x86_64_page_table_walker dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic logic [W_ADDR-1:0] table_entry_addr(logic [W_ADDR-1:0] base,
                                                           logic [W_LEVEL-1:0] lvl);
        int sh;
        logic [W_IDX-1:0] idx;
        sh = 48 - 9 * int'(lvl);
        idx = W_IDX'(mdl_va >> sh);
        return base + W_ADDR'({idx, 3'b000});
    endfunction

    task automatic predict_walk_step(input t_walk_item it);
        t_walk_result r;
        logic [W_ADDR-1:0] frame;
        r = '{default: '0};
        if (it.kind == KIND_START) begin
            mdl_va = it.va;
            mdl_level = mdl_five ? LVL_PML5 : LVL_PML4;
            mdl_busy = 1'b1;
            r.kind = RES_REQUEST;
            r.req = table_entry_addr({it.root[W_ADDR-1:PAGE_BITS], PAGE_BITS'(0)}, mdl_level);
            expected_walk_results.push_back(r);
            return;
        end
        if (!mdl_busy)
            return;
        frame = {it.entry[W_ADDR-1:PAGE_BITS], PAGE_BITS'(0)};
        r.kind = RES_FINISH;
        mdl_busy = 1'b0;
        if (!it.ok) begin
            r.status = ST_READ_FAIL;
            r.level = mdl_level;
        end else if (!it.entry[BIT_PRESENT]) begin
            r.status = ST_NOT_PRESENT;
            r.level = mdl_level;
        end else if (mdl_level == LVL_PDPT && it.entry[BIT_PS]) begin
            r.pa = frame + W_ADDR'(mdl_va[29:0]);
            r.page_sz = SZ_1G;
        end else if (mdl_level == LVL_PD && it.entry[BIT_PS]) begin
            r.pa = frame + W_ADDR'(mdl_va[20:0]);
            r.page_sz = SZ_2M;
        end else if (mdl_level >= LVL_PT) begin
            r.pa = frame + W_ADDR'(mdl_va[11:0]);
            r.page_sz = SZ_4K;
        end else begin
            mdl_busy = 1'b1;
            mdl_level = mdl_level + 3'd1;
            r.kind = RES_REQUEST;
            r.req = table_entry_addr(frame, mdl_level);
        end
        expected_walk_results.push_back(r);
    endtask

    task automatic flag_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("%0t: %s mismatch: got %h, expected %h", $realtime, field, got, want);
        mismatch_cnt++;
    endtask

    // hand items to the walker, predicting each one as it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                predict_walk_step(cur_item);
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (walk_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_item = walk_items.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata <= W_S_DATA'({cur_item.ok, cur_item.entry, cur_item.va,
                                                 cur_item.root});
                    i_s_axis_tuser <= cur_item.kind;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : recv_ready
        int hold_left;
        bit hold_used;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            hold_left = 0;
            hold_used = 0;
        end else begin
            if (hold_start && !hold_used) begin
                hold_left = HOLD_CYCLES;
                hold_used = 1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : check_walk_results
        t_walk_result want;
        logic [W_M_DATA-1:0] d;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            d = o_m_axis_tdata;
            if (expected_walk_results.size() == 0) begin
                flag_mismatch("unexpected item", 64'(d[M_REQ_LSB +: W_ADDR]), '0);
            end else begin
                want = expected_walk_results.pop_front();
                if (o_m_axis_tuser !== want.kind)
                    flag_mismatch("result_kind", 64'(o_m_axis_tuser), 64'(want.kind));
                if (d[M_REQ_LSB +: W_ADDR] !== want.req)
                    flag_mismatch("request_address", 64'(d[M_REQ_LSB +: W_ADDR]),
                                  64'(want.req));
                if (d[M_PA_LSB +: W_ADDR] !== want.pa)
                    flag_mismatch("physical_address", 64'(d[M_PA_LSB +: W_ADDR]),
                                  64'(want.pa));
                if (d[M_STATUS_LSB +: W_STATUS] !== want.status)
                    flag_mismatch("status", 64'(d[M_STATUS_LSB +: W_STATUS]),
                                  64'(want.status));
                if (d[M_FAIL_LSB +: W_LEVEL] !== want.level)
                    flag_mismatch("fail_level", 64'(d[M_FAIL_LSB +: W_LEVEL]),
                                  64'(want.level));
                if (d[M_SIZE_LSB +: W_SIZE] !== want.page_sz)
                    flag_mismatch("leaf_size", 64'(d[M_SIZE_LSB +: W_SIZE]),
                                  64'(want.page_sz));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [W_ENTRY-1:0] rand_entry();
        logic [W_ENTRY-1:0] e;
        e = {$urandom, $urandom};
        // push some frames near the top so the address sum wraps
        if ($urandom_range(9) == 0)
            e[W_ADDR-1:30] = '1;
        return e;
    endfunction

    task automatic add_item(input logic kind, input logic [W_ADDR-1:0] root,
                            input logic [W_VA-1:0] va, input logic [W_ENTRY-1:0] entry,
                            input logic ok, input bit counted);
        t_walk_item it;
        it.kind = kind;
        it.root = root;
        it.va = va;
        it.entry = entry;
        it.ok = ok;
        walk_items.push_back(it);
        if (counted)
            stim_count++;
    endtask

    task automatic add_start(input logic [W_ADDR-1:0] root, input logic [W_VA-1:0] va);
        add_item(KIND_START, root, va, rand_entry(), 1'($urandom_range(1)), 1);
    endtask

    task automatic add_reply(input logic [W_ENTRY-1:0] entry, input logic ok);
        add_item(KIND_REPLY, W_ADDR'({$urandom, $urandom}), W_VA'({$urandom, $urandom}),
                 entry, ok, 1);
    endtask

    task automatic add_walk(input bit five);
        logic [W_LEVEL-1:0] lvl;
        logic [W_ENTRY-1:0] e;
        int r;
        add_start(W_ADDR'({$urandom, $urandom}), W_VA'({$urandom, $urandom}));
        lvl = five ? LVL_PML5 : LVL_PML4;
        forever begin
            r = $urandom_range(99);
            e = rand_entry();
            if (r < 4)
                return;
            if (r < 8) begin
                add_reply(e, 1'b0);
                return;
            end
            if (r < 12) begin
                e[BIT_PRESENT] = 1'b0;
                add_reply(e, 1'b1);
                return;
            end
            e[BIT_PRESENT] = 1'b1;
            if (lvl == LVL_PDPT || lvl == LVL_PD)
                e[BIT_PS] = ($urandom_range(3) == 0);
            add_reply(e, 1'b1);
            if (lvl >= LVL_PT || ((lvl == LVL_PDPT || lvl == LVL_PD) && e[BIT_PS]))
                return;
            lvl = lvl + 3'd1;
        end
    endtask

    task automatic add_random_walks(input bit five, input int n);
        stim_count = 0;
        while (stim_count < n) begin
            add_walk(five);
            // stray reply, dropped by the block when no walk is running
            if ($urandom_range(19) == 0)
                add_item(KIND_REPLY, '0, '0, rand_entry(), 1'($urandom_range(1)), 0);
        end
    endtask

    task automatic wait_walks_drained();
        while (walk_items.size() != 0 || i_s_axis_tvalid || expected_walk_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_five_level(input logic value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= W_PADDR'(4 * int'(REG_FIVE_LEVEL));
        pwdata <= W_PDATA'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        mdl_five = value;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 18;
        recv_idle_pct = 70;
        write_five_level(1'b0);
        add_item(KIND_REPLY, '1, '1, '1, 1'b1, 0);
        add_start('1, '1);
        add_reply('1, 1'b1);
        add_reply('1, 1'b1);
        add_start('0, '0);
        add_reply('0, 1'b0);
        add_start(W_ADDR'({$urandom, $urandom}), W_VA'({$urandom, $urandom}));
        add_reply(E_PRESENT, 1'b1);
        add_reply('1 & ~E_PRESENT, 1'b1);
        add_start(W_ADDR'({$urandom, $urandom}), W_VA'({$urandom, $urandom}));
        add_reply(E_PRESENT, 1'b1);
        add_reply(E_PRESENT, 1'b1);
        add_reply(rand_entry() | E_PRESENT | E_PS, 1'b1);
        add_start(W_ADDR'({$urandom, $urandom}), W_VA'({$urandom, $urandom}));
        add_reply(E_PRESENT | E_PS, 1'b1);
        add_reply(E_PRESENT, 1'b1);
        add_reply(E_PRESENT, 1'b1);
        add_reply('1, 1'b1);
        add_start(W_ADDR'({$urandom, $urandom}), W_VA'({$urandom, $urandom}));
        add_start(W_ADDR'({$urandom, $urandom}), W_VA'({$urandom, $urandom}));
        add_reply('0, 1'b1);
        add_random_walks(1'b0, 150);

        wait_walks_drained();
        send_idle_pct = 70;
        recv_idle_pct = 18;
        write_five_level(1'b1);
        add_start('1, '1);
        add_reply('1, 1'b1);
        add_reply('1, 1'b1);
        add_reply('1, 1'b1);
        add_reply(E_PRESENT, 1'b1);
        add_reply(E_PRESENT & 64'h0, 1'b1);
        add_start(W_ADDR'({$urandom, $urandom}), W_VA'({$urandom, $urandom}));
        add_reply('1, 1'b0);
        add_random_walks(1'b1, 150);

        wait_walks_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_five_level(1'b0);
        add_random_walks(1'b0, 150);
        @(posedge i_clk);
        hold_start <= 1'b1;

        wait_walks_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/ptw_pkg.sv
design/x86_64_page_table_walker.sv
design/ptw_chk.sv
tb/sv/x86_64_page_table_walker_tb.sv
